// File: hw/rtl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

  localparam int SymbolCountDef = 256;
  localparam int MaxCodeLenDef  = 16;

  localparam int SymW      = 8;
  localparam int CodeWordW = 16;
  localparam int CodeLenW  = 5;
  localparam int FuncW     = 2;
  localparam int ByteW     = 8;
  localparam int EntryW    = CodeWordW + CodeLenW;
  localparam int InDataW   = 32;

  typedef enum logic [FuncW-1:0] {
    FuncLoad   = 2'd0,
    FuncEncode = 2'd1,
    FuncFlush  = 2'd2
  } func_e;

endpackage

// File: hw/rtl/huffman_code_bit_packer_unit.sv
// Top level of the table-driven Huffman encoder with byte-wide bit packer.
//
//   Channel   Direction  tdata / tuser contents                       Notes
//   s_axis    in         tdata: symbol, code_word, code_length         tuser: func
//   m_axis    out        tdata: packed_byte                            tlast: last
//
// An item is taken in every cycle while the lookup stage can move on; an encode
// reads the code table RAM through its registered read port and is packed from
// that entry once the lookup stage can advance. The single byte-wide output port
// sets the rate: the packer takes a new item only while no byte is held, or one
// is held and m_axis is ready, so an item that yields two bytes stalls the next.
// After reset the table reads as empty at once through per-entry valid flags;
// there is no clearing pass. Output stalls back up through the packer to s_axis.
module huffman_code_bit_packer_unit #(
  parameter int SYMBOL_COUNT = hcbp_pkg::SymbolCountDef,
  parameter int MAX_CODE_LEN = hcbp_pkg::MaxCodeLenDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // symbol [7:0], code_word [23:8], code_length [28:24], zero [31:29]
  input  logic [hcbp_pkg::InDataW-1:0] s_axis_tdata,
  // func [1:0]
  input  logic [hcbp_pkg::FuncW-1:0]   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // packed_byte [7:0]
  output logic [hcbp_pkg::ByteW-1:0]   m_axis_tdata,
  output logic                        m_axis_tlast
);
  import hcbp_pkg::*;

  localparam int IdxW     = $clog2(SYMBOL_COUNT);
  localparam int LenLimit = (MAX_CODE_LEN < CodeWordW) ? MAX_CODE_LEN : CodeWordW;

  func_e                in_func;
  logic [SymW-1:0]      in_sym;
  logic [CodeWordW-1:0] in_word;
  logic [CodeLenW-1:0]  in_len;
  logic [CodeLenW-1:0]  sat_len;
  logic [IdxW-1:0]      in_idx;
  logic                 in_range;
  logic                 in_fire;
  logic                 load_we;
  logic                 enc_re;
  logic                 s1_take;

  logic [SYMBOL_COUNT-1:0] valid_q, valid_d;
  logic [EntryW-1:0]       ram_rdata;

  logic s1_valid_q, s1_valid_d;
  logic s1_flush_q, s1_flush_d;
  logic s1_hit_q, s1_hit_d;
  logic s1_adv;
  logic can_take;
  logic out_fire;

  logic [ByteW-1:0]    buf_q, buf_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [1:0]          hold_n_q, hold_n_d;
  logic [ByteW-1:0]    hold_b0_q, hold_b0_d;
  logic [ByteW-1:0]    hold_b1_q, hold_b1_d;

  logic [CodeLenW-1:0]  eff_len;
  logic [CodeLenW-1:0]  shamt;
  logic [CodeWordW-1:0] code_al;
  logic [23:0]          win;
  logic [CodeLenW-1:0]  total;
  logic [1:0]           new_n;
  logic [ByteW-1:0]     new_b0, new_b1;

  assign in_func  = func_e'(s_axis_tuser);
  assign in_sym   = s_axis_tdata[7:0];
  assign in_word  = s_axis_tdata[23:8];
  assign in_len   = s_axis_tdata[28:24];
  assign in_idx   = in_sym[IdxW-1:0];
  assign in_range = ({1'b0, in_sym} < 9'(SYMBOL_COUNT));
  assign sat_len  = (in_len > CodeLenW'(LenLimit)) ? CodeLenW'(LenLimit) : in_len;

  assign out_fire      = m_axis_tvalid & m_axis_tready;
  assign can_take      = (hold_n_q == 2'd0) | ((hold_n_q == 2'd1) & m_axis_tready);
  assign s1_adv        = s1_valid_q & can_take;
  assign s_axis_tready = ~s1_valid_q | s1_adv;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  always_comb begin
    load_we = 1'b0;
    enc_re  = 1'b0;
    s1_take = 1'b0;
    unique case (in_func)
      FuncLoad: begin
        load_we = in_fire & in_range;
      end
      FuncEncode: begin
        enc_re  = in_fire & in_range;
        s1_take = in_range;
      end
      FuncFlush: begin
        s1_take = 1'b1;
      end
      default: begin
      end
    endcase
  end

  hcbp_ram #(
    .Width(EntryW),
    .Depth(SYMBOL_COUNT)
  ) u_code_ram (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(in_idx),
    .wdata_i({sat_len, in_word}),
    .re_i   (enc_re),
    .raddr_i(in_idx),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    valid_d = valid_q;
    if (load_we) begin
      valid_d[in_idx] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_flush_d = s1_flush_q;
    s1_hit_d   = s1_hit_q;
    if (in_fire) begin
      s1_valid_d = s1_take;
      s1_flush_d = (in_func == FuncFlush);
      s1_hit_d   = valid_q[in_idx];
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // Packing: the code is left-aligned and merged below the held bits.
  assign eff_len = s1_hit_q ? ram_rdata[EntryW-1:CodeWordW] : '0;
  assign shamt   = CodeLenW'(CodeWordW) - eff_len;
  assign code_al = ram_rdata[CodeWordW-1:0] << shamt;
  assign win     = {buf_q, 16'b0} | ({code_al, 8'b0} >> cnt_q);
  assign total   = CodeLenW'(cnt_q) + eff_len;

  always_comb begin
    if (s1_flush_q) begin
      new_n  = (cnt_q != 3'd0) ? 2'd1 : 2'd0;
      new_b0 = buf_q;
      new_b1 = '0;
    end else begin
      new_n  = total[4:3];
      new_b0 = win[23:16];
      new_b1 = win[15:8];
    end
  end

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (s1_adv) begin
      if (s1_flush_q) begin
        buf_d = '0;
        cnt_d = '0;
      end else begin
        cnt_d = total[2:0];
        case (new_n)
          2'd0:    buf_d = win[23:16];
          2'd1:    buf_d = win[15:8];
          default: buf_d = win[7:0];
        endcase
      end
    end
  end

  always_comb begin
    hold_n_d  = hold_n_q;
    hold_b0_d = hold_b0_q;
    hold_b1_d = hold_b1_q;
    if (s1_adv) begin
      hold_n_d  = new_n;
      hold_b0_d = new_b0;
      hold_b1_d = new_b1;
    end else if (out_fire) begin
      hold_n_d  = hold_n_q - 2'd1;
      hold_b0_d = hold_b1_q;
    end
  end

  assign m_axis_tvalid = (hold_n_q != 2'd0);
  assign m_axis_tdata  = hold_b0_q;
  assign m_axis_tlast  = (hold_n_q == 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
      s1_hit_q   <= 1'b0;
      buf_q      <= '0;
      cnt_q      <= '0;
      hold_n_q   <= '0;
    end else begin
      valid_q    <= valid_d;
      s1_valid_q <= s1_valid_d;
      s1_flush_q <= s1_flush_d;
      s1_hit_q   <= s1_hit_d;
      buf_q      <= buf_d;
      cnt_q      <= cnt_d;
      hold_n_q   <= hold_n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_b0_q <= hold_b0_d;
    hold_b1_q <= hold_b1_d;
  end

endmodule

// File: hw/rtl/hcbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module hcbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
